// ----- hdl/slc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_pkg : shared types and constants for the source line classifier
// Line phase encoding and the character codes the scanner looks for.
// ----------------------------------------------------------------------------
package slc_pkg;

  typedef enum logic [2:0] {
    PH_START       = 3'd0,  // line start, skipping blanks
    PH_SLASH       = 3'd1,  // first char was a slash
    PH_SCAN        = 3'd2,  // inside block, looking for the closer
    PH_AFTER       = 3'd3,  // skipping blanks after a closer
    PH_AFTER_SLASH = 3'd4,  // slash seen after a closer
    PH_DONE        = 3'd5   // line decided, rest ignored
  } line_phase_t;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_HASH  = 8'd35;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;

  localparam int unsigned OUT_WIDTH = 32;

endpackage

// ----- hdl/source_line_classifier.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_line_classifier : byte-stream line counter (total / code / comment)
// Classifies each line of a text stream and reports three saturating counts
// when the request marked final has been processed.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake                payload
//  -------   ---   ----------------------   ----------------------------------
//  text      in    text_valid / text_stall  text_byte[7:0], final_byte
//  count     out   count_valid / count_stall total_count, code_count,
//                                           comment_count (32 bits each)
//
//  One text request is taken per cycle while text_stall is low. A request is
//  held in the input register, then the phase update and counter increments
//  run in one pass. count_valid rises once a final request has passed the
//  input register and its counts are loaded into the result register.
//  text_stall rises only when a final request waits in the input register
//  while the previous result is still held by count_stall; other bytes go on.
//  Synchronous reset clears the phase, block flag, counters and valid flags.
//  The final request also returns all line state to its reset values.
//
module source_line_classifier #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        text_valid,
  output logic             text_stall,
  input  wire logic [7:0]  text_byte,
  input  wire logic        final_byte,
  output logic             count_valid,
  input  wire logic        count_stall,
  output logic [31:0]      total_count,
  output logic [31:0]      code_count,
  output logic [31:0]      comment_count
);
  import slc_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_final;

  // line state
  line_phase_t line_phase, line_phase_next;
  logic        inside_block, inside_block_next;
  logic        star_seen, star_seen_next;
  logic [COUNT_WIDTH-1:0] lines_total, lines_code, lines_comment;
  logic [COUNT_WIDTH-1:0] total_next, code_next, comment_next;

  logic inc_total, inc_code, inc_comment;
  logic is_nl, is_blank;
  logic process;
  logic count_valid_next;
  logic [31:0] total_clip, code_clip, comment_clip;

  // A final byte cannot be retired while the result register is still held.
  assign process    = in_valid && !(in_final && count_valid && count_stall);
  assign text_stall = in_valid && !process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!text_stall) begin
      in_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!text_stall) begin
      in_byte  <= text_byte;
      in_final <= final_byte;
    end
  end

  assign is_nl    = (in_byte == CH_NL);
  assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_CR);

  // One byte of the line scanner, then the implicit line end of a final byte.
  always_comb begin
    line_phase_next   = line_phase;
    inside_block_next = inside_block;
    star_seen_next    = star_seen;
    inc_total         = 1'b0;
    inc_code          = 1'b0;
    inc_comment       = 1'b0;
    if (is_nl) begin
      inc_total       = 1'b1;
      inc_code        = (line_phase == PH_SLASH) || (line_phase == PH_AFTER_SLASH);
      line_phase_next = PH_START;
      star_seen_next  = 1'b0;
    end else begin
      case (line_phase)
        PH_START: begin
          if (!is_blank) begin
            if (inside_block) begin
              // nonblank line inside a block; this byte already scans
              inc_comment     = 1'b1;
              line_phase_next = PH_SCAN;
              star_seen_next  = (in_byte == CH_STAR);
            end else if (in_byte == CH_SLASH) begin
              line_phase_next = PH_SLASH;
            end else if (in_byte == CH_HASH) begin
              inc_comment     = 1'b1;
              line_phase_next = PH_DONE;
            end else begin
              inc_code        = 1'b1;
              line_phase_next = PH_DONE;
            end
          end
        end
        PH_SLASH: begin
          if (in_byte == CH_STAR) begin
            inc_comment       = 1'b1;
            inside_block_next = 1'b1;
            star_seen_next    = 1'b0;
            line_phase_next   = PH_SCAN;
          end else if (in_byte == CH_SLASH) begin
            inc_comment     = 1'b1;
            line_phase_next = PH_DONE;
          end else begin
            inc_code        = 1'b1;
            line_phase_next = PH_DONE;
          end
        end
        PH_SCAN: begin
          if (star_seen && (in_byte == CH_SLASH)) begin
            inside_block_next = 1'b0;
            star_seen_next    = 1'b0;
            line_phase_next   = PH_AFTER;
          end else begin
            star_seen_next = (in_byte == CH_STAR);
          end
        end
        PH_AFTER: begin
          if (!is_blank) begin
            if (in_byte == CH_SLASH) begin
              line_phase_next = PH_AFTER_SLASH;
            end else begin
              inc_code        = (in_byte != CH_HASH);
              line_phase_next = PH_DONE;
            end
          end
        end
        PH_AFTER_SLASH: begin
          inc_code        = (in_byte != CH_SLASH);
          line_phase_next = PH_DONE;
        end
        default: begin
        end
      endcase
      // an unterminated last line is closed here
      if (in_final) begin
        inc_total = 1'b1;
        if ((line_phase_next == PH_SLASH) || (line_phase_next == PH_AFTER_SLASH)) begin
          inc_code = 1'b1;
        end
      end
    end
  end

  // saturating counters
  assign total_next   = (inc_total && !(&lines_total)) ? lines_total + 1'b1 : lines_total;
  assign code_next    = (inc_code && !(&lines_code)) ? lines_code + 1'b1 : lines_code;
  assign comment_next = (inc_comment && !(&lines_comment)) ? lines_comment + 1'b1
                                                            : lines_comment;

  // clip or widen to the 32-bit result fields
  generate
    if (COUNT_WIDTH > OUT_WIDTH) begin : g_clip
      assign total_clip   = (|total_next[COUNT_WIDTH-1:OUT_WIDTH]) ? '1
                                                                  : total_next[OUT_WIDTH-1:0];
      assign code_clip    = (|code_next[COUNT_WIDTH-1:OUT_WIDTH]) ? '1
                                                                 : code_next[OUT_WIDTH-1:0];
      assign comment_clip = (|comment_next[COUNT_WIDTH-1:OUT_WIDTH]) ? '1
                                                                    : comment_next[OUT_WIDTH-1:0];
    end else begin : g_wide
      assign total_clip   = OUT_WIDTH'(total_next);
      assign code_clip    = OUT_WIDTH'(code_next);
      assign comment_clip = OUT_WIDTH'(comment_next);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase    <= PH_START;
      inside_block  <= 1'b0;
      star_seen     <= 1'b0;
      lines_total   <= '0;
      lines_code    <= '0;
      lines_comment <= '0;
    end else if (process) begin
      if (in_final) begin
        line_phase    <= PH_START;
        inside_block  <= 1'b0;
        star_seen     <= 1'b0;
        lines_total   <= '0;
        lines_code    <= '0;
        lines_comment <= '0;
      end else begin
        line_phase    <= line_phase_next;
        inside_block  <= inside_block_next;
        star_seen     <= star_seen_next;
        lines_total   <= total_next;
        lines_code    <= code_next;
        lines_comment <= comment_next;
      end
    end
  end

  // result register
  assign count_valid_next = (process && in_final) || (count_valid && count_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= 1'b0;
    end else begin
      count_valid <= count_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (process && in_final) begin
      total_count   <= total_clip;
      code_count    <= code_clip;
      comment_count <= comment_clip;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/slc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slc_checker : port-level checks for the source line classifier
// Watches both channels and is bound to the top level below.
// ----------------------------------------------------------------------------
module slc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        text_valid,
  input wire logic        text_stall,
  input wire logic [7:0]  text_byte,
  input wire logic        final_byte,
  input wire logic        count_valid,
  input wire logic        count_stall,
  input wire logic [31:0] total_count,
  input wire logic [31:0] code_count,
  input wire logic [31:0] comment_count
);

  // stalled text request stays offered and unchanged
  a_text_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_stall |=> text_valid && $stable(text_byte)
                                 && $stable(final_byte))
    else $error("text request changed while stalled");

  // held result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    count_valid && count_stall |=> count_valid)
    else $error("count_valid dropped while stalled");

  // held result does not change
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    count_valid && count_stall |=> $stable(total_count) && $stable(code_count)
                                   && $stable(comment_count))
    else $error("count payload changed while stalled");

  // every text ends at least one line
  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    count_valid |-> total_count != 32'd0)
    else $error("result with zero total lines");

  // input backpressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> count_valid && count_stall)
    else $error("text_stall without a stalled result");

endmodule

bind source_line_classifier slc_checker u_slc_checker (
  .clk          (clk),
  .rst          (rst),
  .text_valid   (text_valid),
  .text_stall   (text_stall),
  .text_byte    (text_byte),
  .final_byte   (final_byte),
  .count_valid  (count_valid),
  .count_stall  (count_stall),
  .total_count  (total_count),
  .code_count   (code_count),
  .comment_count(comment_count)
);
`default_nettype wire
